/* rtl/lc2d_pkg.sv */
// Shared definitions for the 2D line clipper: default widths, register
// indexes, outcode bit positions and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package lc2d_pkg;

  localparam int COORD_WIDTH_DEF = 16;

  // Configuration register indexes.
  localparam int CFG_INDEX_WIDTH = 2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_WINDOW_LEFT   = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_WINDOW_TOP    = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_WINDOW_RIGHT  = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_WINDOW_BOTTOM = 2'd3;

  localparam int WIN_RIGHT_RESET  = 639;
  localparam int WIN_BOTTOM_RESET = 479;

  // Outcode bit positions.
  localparam int OC_LEFT   = 0;
  localparam int OC_RIGHT  = 1;
  localparam int OC_TOP    = 2;
  localparam int OC_BOTTOM = 3;

  // Quotient magnitudes saturate at 2**QUOT_CAP_LOG2.
  localparam int QUOT_CAP_LOG2 = 40;

  localparam int MOVE_CNT_WIDTH = 3;
  localparam logic [MOVE_CNT_WIDTH-1:0] MAX_MOVES = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_DLOAD,
    ST_DIV,
    ST_ROUND,
    ST_UPDATE
  } state_t;

endpackage

/* rtl/lc2d_if.sv */
// Channel interfaces of the 2D line clipper: segment input and clip result.
// Depends on lc2d_pkg for the default coordinate width.
`timescale 1ns / 1ps

interface lc2d_in_if #(
  parameter int W = lc2d_pkg::COORD_WIDTH_DEF
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] start_x;
  logic signed [W-1:0] start_y;
  logic signed [W-1:0] end_x;
  logic signed [W-1:0] end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lc2d_out_if #(
  parameter int W = lc2d_pkg::COORD_WIDTH_DEF
);
  logic                valid;
  logic                ready;
  logic                visible;
  logic signed [W-1:0] clipped_start_x;
  logic signed [W-1:0] clipped_start_y;
  logic signed [W-1:0] clipped_end_x;
  logic signed [W-1:0] clipped_end_y;

  modport source (output valid, visible, clipped_start_x, clipped_start_y,
                  clipped_end_x, clipped_end_y, input ready);
  modport sink   (input valid, visible, clipped_start_x, clipped_start_y,
                  clipped_end_x, clipped_end_y, output ready);
endinterface

/* rtl/lc2d_div.sv */
// Serial restoring divider, two quotient bits per cycle: a 2W-bit dividend
// by a W-bit divisor. Stand-alone; no package dependencies.
`timescale 1ns / 1ps

module lc2d_div #(
  parameter int W = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [2*W-1:0]  dividend,
  input  logic [W-1:0]    divisor,
  output logic            done,
  output logic [2*W-1:0]  quotient,
  output logic [W-1:0]    remainder
);

  localparam int PW    = 2 * W;
  localparam int CNT_W = $clog2(W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [W-1:0]     rem_r, rem_nxt;
  logic [W-1:0]     div_r;
  logic [PW-1:0]    dq_r, dq_nxt;

  // Dividend bits shift out at the top of dq_r while quotient bits enter below.
  always_comb begin
    logic [W:0] trial;
    logic       ge;
    rem_nxt = rem_r;
    dq_nxt  = dq_r;
    for (int i = 0; i < 2; i++) begin
      trial   = {rem_nxt, dq_nxt[PW-1]};
      ge      = trial >= {1'b0, div_r};
      trial   = ge ? trial - {1'b0, div_r} : trial;
      rem_nxt = trial[W-1:0];
      dq_nxt  = {dq_nxt[PW-2:0], ge};
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
    end else if (busy_r && cnt_r == '0) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dq_r  <= dividend;
      div_r <= divisor;
      cnt_r <= CNT_LAST;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dq_r  <= dq_nxt;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign done      = done_r;
  assign quotient  = dq_r;
  assign remainder = rem_r;

endmodule

/* rtl/line_clipper_2d.sv */
// Each endpoint move runs multiply, divider load, serial divide at two bits per
// cycle, round and update; a move along an axis-parallel segment goes straight
// to update. A segment needing no move is decided in the check state. One
// segment at a time. The divider sets the pace. Synchronous active-low reset
// clears the sequencer and the output valid and restores the default window.
`timescale 1ns / 1ps

module line_clipper_2d #(
  parameter int COORD_WIDTH = lc2d_pkg::COORD_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  lc2d_in_if.sink                               in_ch,
  lc2d_out_if.source                            out_ch,
  input  logic                                  cfg_we,
  input  logic [lc2d_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [COORD_WIDTH-1:0]                cfg_wdata
);

  localparam int W   = COORD_WIDTH;
  localparam int PW  = 2 * W;
  localparam int CAP = lc2d_pkg::QUOT_CAP_LOG2;
  localparam int QW  = (PW + 1 > CAP + 1) ? PW + 1 : CAP + 1;
  localparam int OW  = QW + 1;
  localparam int SW  = OW + 1;

  function automatic logic [3:0] outcode(
    input logic signed [W-1:0] x,
    input logic signed [W-1:0] y,
    input logic signed [W-1:0] l,
    input logic signed [W-1:0] t,
    input logic signed [W-1:0] r,
    input logic signed [W-1:0] b
  );
    logic [3:0] c;
    c = '0;
    if (x < l) c[lc2d_pkg::OC_LEFT] = 1'b1;
    else if (x > r) c[lc2d_pkg::OC_RIGHT] = 1'b1;
    if (y < t) c[lc2d_pkg::OC_TOP] = 1'b1;
    else if (y > b) c[lc2d_pkg::OC_BOTTOM] = 1'b1;
    return c;
  endfunction

  function automatic logic [W-1:0] magnitude(input logic signed [W:0] v);
    logic [W:0] a;
    a = v[W] ? -v : v;
    return a[W-1:0];
  endfunction

  // Window registers.
  logic signed [W-1:0] win_l_r, win_t_r, win_r_r, win_b_r;

  // Working segment.
  logic signed [W-1:0] p0x_r, p0y_r, p1x_r, p1y_r;
  logic signed [W:0]   dx_r, dy_r;
  logic [lc2d_pkg::MOVE_CNT_WIDTH-1:0] moves_r;

  // Current move.
  logic                sel_r;
  logic                snap_x_r;
  logic signed [W-1:0] edge_r;
  logic signed [W-1:0] base_r;
  logic [W-1:0]        mag_a_r, mag_b_r, den_r;
  logic                neg_r;
  logic [PW-1:0]       prod_r;
  logic signed [OW-1:0] ofs_r;

  // Result register.
  logic                out_valid_r;
  logic                vis_r;
  logic signed [W-1:0] o_sx_r, o_sy_r, o_ex_r, o_ey_r;

  lc2d_pkg::state_t state_r, state_nxt;

  logic            in_fire, out_free;
  logic [3:0]      c0, c1, ck;
  logic            k, accept_seg, reject_seg, finish;
  logic            snap_x, den_zero;
  logic signed [W-1:0] edge_v, pkx, pky, base_v;
  logic signed [W:0]   diff, num, den;

  logic            div_start, div_done;
  logic [PW-1:0]   quo;
  logic [W-1:0]    rem;

  logic            round_up;
  logic [PW:0]     q_full;
  logic [QW-1:0]   q_ext, q_cap;
  logic signed [OW-1:0] ofs_v;
  logic signed [SW-1:0] sum;
  logic signed [W-1:0]  moved;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // Outcodes are derived from the current endpoints every time around the loop.
  always_comb begin
    c0 = outcode(p0x_r, p0y_r, win_l_r, win_t_r, win_r_r, win_b_r);
    c1 = outcode(p1x_r, p1y_r, win_l_r, win_t_r, win_r_r, win_b_r);
    accept_seg = (c0 | c1) == '0;
    reject_seg = ((c0 & c1) != '0) || (moves_r == lc2d_pkg::MAX_MOVES);
    k   = (c0 == '0);
    ck  = k ? c1 : c0;
    pkx = k ? p1x_r : p0x_r;
    pky = k ? p1y_r : p0y_r;
    if (ck[lc2d_pkg::OC_LEFT]) begin
      snap_x = 1'b1;
      edge_v = win_l_r;
    end else if (ck[lc2d_pkg::OC_RIGHT]) begin
      snap_x = 1'b1;
      edge_v = win_r_r;
    end else if (ck[lc2d_pkg::OC_TOP]) begin
      snap_x = 1'b0;
      edge_v = win_t_r;
    end else begin
      snap_x = 1'b0;
      edge_v = win_b_r;
    end
    diff = snap_x ? ($signed({edge_v[W-1], edge_v}) - $signed({pkx[W-1], pkx}))
                  : ($signed({edge_v[W-1], edge_v}) - $signed({pky[W-1], pky}));
    num    = snap_x ? dy_r : dx_r;
    den    = snap_x ? dx_r : dy_r;
    base_v = snap_x ? pky : pkx;
    den_zero = (den == '0);
  end

  // Round half away from zero, then cap the magnitude.
  always_comb begin
    round_up = rem >= (den_r - rem);
    q_full   = {1'b0, quo} + {{PW{1'b0}}, round_up};
    q_ext    = QW'(q_full);
    q_cap    = (q_ext > (QW'(1) << CAP)) ? (QW'(1) << CAP) : q_ext;
    ofs_v    = neg_r ? -$signed({1'b0, q_cap}) : $signed({1'b0, q_cap});
  end

  // Saturating add of the offset onto the unsnapped coordinate.
  always_comb begin
    sum = SW'(base_r) + SW'(ofs_r);
    if (sum[SW-1:W-1] == '0 || sum[SW-1:W-1] == '1) begin
      moved = sum[W-1:0];
    end else begin
      moved = sum[SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lc2d_pkg::ST_IDLE: begin
        if (in_fire) state_nxt = lc2d_pkg::ST_CHECK;
      end
      lc2d_pkg::ST_CHECK: begin
        if (accept_seg || reject_seg) begin
          if (out_free) state_nxt = lc2d_pkg::ST_IDLE;
        end else if (den_zero) begin
          state_nxt = lc2d_pkg::ST_UPDATE;
        end else begin
          state_nxt = lc2d_pkg::ST_MUL;
        end
      end
      lc2d_pkg::ST_MUL:    state_nxt = lc2d_pkg::ST_DLOAD;
      lc2d_pkg::ST_DLOAD:  state_nxt = lc2d_pkg::ST_DIV;
      lc2d_pkg::ST_DIV: begin
        if (div_done) state_nxt = lc2d_pkg::ST_ROUND;
      end
      lc2d_pkg::ST_ROUND:  state_nxt = lc2d_pkg::ST_UPDATE;
      lc2d_pkg::ST_UPDATE: state_nxt = lc2d_pkg::ST_CHECK;
      default:             state_nxt = lc2d_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ch.ready = 1'b0;
    div_start   = 1'b0;
    finish      = 1'b0;
    case (state_r)
      lc2d_pkg::ST_IDLE:  in_ch.ready = 1'b1;
      lc2d_pkg::ST_CHECK: finish = (accept_seg || reject_seg) && out_free;
      lc2d_pkg::ST_DLOAD: div_start = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lc2d_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      win_l_r     <= '0;
      win_t_r     <= '0;
      win_r_r     <= W'(lc2d_pkg::WIN_RIGHT_RESET);
      win_b_r     <= W'(lc2d_pkg::WIN_BOTTOM_RESET);
    end else begin
      state_r <= state_nxt;
      if (finish) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          lc2d_pkg::CFG_WINDOW_LEFT:   win_l_r <= cfg_wdata;
          lc2d_pkg::CFG_WINDOW_TOP:    win_t_r <= cfg_wdata;
          lc2d_pkg::CFG_WINDOW_RIGHT:  win_r_r <= cfg_wdata;
          lc2d_pkg::CFG_WINDOW_BOTTOM: win_b_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      p0x_r   <= in_ch.start_x;
      p0y_r   <= in_ch.start_y;
      p1x_r   <= in_ch.end_x;
      p1y_r   <= in_ch.end_y;
      dx_r    <= $signed({in_ch.end_x[W-1], in_ch.end_x})
               - $signed({in_ch.start_x[W-1], in_ch.start_x});
      dy_r    <= $signed({in_ch.end_y[W-1], in_ch.end_y})
               - $signed({in_ch.start_y[W-1], in_ch.start_y});
      moves_r <= '0;
    end
    if (state_r == lc2d_pkg::ST_CHECK) begin
      sel_r    <= k;
      snap_x_r <= snap_x;
      edge_r   <= edge_v;
      base_r   <= base_v;
      mag_a_r  <= magnitude(num);
      mag_b_r  <= magnitude(diff);
      den_r    <= magnitude(den);
      neg_r    <= num[W] ^ diff[W] ^ den[W];
      if (den_zero) ofs_r <= '0;
    end
    if (state_r == lc2d_pkg::ST_MUL) prod_r <= mag_a_r * mag_b_r;
    if (state_r == lc2d_pkg::ST_ROUND) ofs_r <= ofs_v;
    if (state_r == lc2d_pkg::ST_UPDATE) begin
      moves_r <= moves_r + 1'b1;
      case ({sel_r, snap_x_r})
        2'b00: begin p0y_r <= edge_r; p0x_r <= moved; end
        2'b01: begin p0x_r <= edge_r; p0y_r <= moved; end
        2'b10: begin p1y_r <= edge_r; p1x_r <= moved; end
        default: begin p1x_r <= edge_r; p1y_r <= moved; end
      endcase
    end
    if (finish) begin
      vis_r  <= accept_seg;
      o_sx_r <= accept_seg ? p0x_r : '0;
      o_sy_r <= accept_seg ? p0y_r : '0;
      o_ex_r <= accept_seg ? p1x_r : '0;
      o_ey_r <= accept_seg ? p1y_r : '0;
    end
  end

  lc2d_div #(
    .W (W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (prod_r),
    .divisor   (den_r),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rem)
  );

  assign out_ch.valid           = out_valid_r;
  assign out_ch.visible         = vis_r;
  assign out_ch.clipped_start_x = o_sx_r;
  assign out_ch.clipped_start_y = o_sy_r;
  assign out_ch.clipped_end_x   = o_ex_r;
  assign out_ch.clipped_end_y   = o_ey_r;

endmodule

/* rtl/lc2d_check.sv */
// Port-level checker for the 2D line clipper, attached to the top level by
// the bind statement at the end of this file. Depends on lc2d_pkg.
`timescale 1ns / 1ps

module lc2d_check #(
  parameter int W = lc2d_pkg::COORD_WIDTH_DEF
) (
  input logic         clk,
  input logic         rst_n,
  input logic         in_valid,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input logic         visible,
  input logic [W-1:0] csx,
  input logic [W-1:0] csy,
  input logic [W-1:0] cex,
  input logic [W-1:0] cey
);

  logic [1:0] pend_r;

  // Transactions accepted on the input whose result has not been taken yet.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {1'b0, in_valid && in_ready} - {1'b0, out_valid && out_ready};
    end
  end

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !visible |-> csx == '0 && csy == '0 && cex == '0 && cey == '0)
    else $error("rejected segment carries nonzero coordinates");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({visible, csx, csy, cex, cey}))
    else $error("stalled result changed or dropped");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transaction was taken");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result offered without an outstanding segment");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> pend_r < 2'd2)
    else $error("ready while two segments are outstanding");

endmodule

bind line_clipper_2d lc2d_check #(
  .W (COORD_WIDTH)
) u_lc2d_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .visible   (out_ch.visible),
  .csx       (out_ch.clipped_start_x),
  .csy       (out_ch.clipped_start_y),
  .cex       (out_ch.clipped_end_x),
  .cey       (out_ch.clipped_end_y)
);

/* dv/tb_top.sv */
// Testbench for line_clipper_2d: drives segments under several clip windows and idle
// patterns, predicts each clip result and checks it field by field.
// Depends on lc2d_pkg, the channel interfaces in lc2d_if.sv and the RTL top level.
`timescale 1ns / 1ps

module tb_top;

  localparam int CW = lc2d_pkg::COORD_WIDTH_DEF;
  localparam longint COORD_MAX = (longint'(1) << (CW - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;
  localparam longint QUOT_LIMIT = longint'(1) << lc2d_pkg::QUOT_CAP_LOG2;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEMS_PER_WINDOW = 103;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    logic   visible;
    coord_t csx;
    coord_t csy;
    coord_t cex;
    coord_t cey;
  } clip_t;

  typedef enum int {
    WIN_DEFAULT,
    WIN_NORMAL,
    WIN_TINY,
    WIN_FULL,
    WIN_INVERTED,
    WIN_WILD
  } window_kind_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [lc2d_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CW-1:0] cfg_wdata;

  lc2d_in_if  #(.W(CW)) seg_if ();
  lc2d_out_if #(.W(CW)) res_if ();

  line_clipper_2d #(.COORD_WIDTH(CW)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (seg_if.sink),
    .out_ch    (res_if.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Window as the block should currently hold it.
  coord_t win_left;
  coord_t win_top;
  coord_t win_right;
  coord_t win_bottom;

  clip_t expected_clips[$];
  clip_t want_clip;
  int errors = 0;
  int cycle_count = 0;
  int send_gap_pct = 0;
  int accept_stall_pct = 0;

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    res_if.ready <= ($urandom_range(99) >= accept_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic longint clamp_coord(input longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  // num * d / den rounded half away from zero, magnitude capped; zero when den is zero.
  function automatic longint edge_offset(input longint num, input longint d,
                                         input longint den);
    logic [63:0]  a, b, v;
    logic [127:0] prod, quo, rem, cap;
    bit           neg;
    if (den == 0) return 0;
    a    = (num < 0) ? 64'(-num) : 64'(num);
    b    = (d < 0) ? 64'(-d) : 64'(d);
    v    = (den < 0) ? 64'(-den) : 64'(den);
    neg  = ((num < 0) != (d < 0)) != (den < 0);
    cap  = 128'(QUOT_LIMIT);
    prod = {64'd0, a} * {64'd0, b};
    if (prod[127:64] >= v) begin
      quo = cap;
    end else begin
      quo = prod / {64'd0, v};
      rem = prod % {64'd0, v};
      if (rem >= {64'd0, v} - rem) quo++;
      if (quo > cap) quo = cap;
    end
    return neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
  endfunction

  function automatic logic [3:0] region_code(input longint x, input longint y,
                                             input longint l, input longint t,
                                             input longint r, input longint b);
    logic [3:0] code;
    code = '0;
    if (x < l) code[lc2d_pkg::OC_LEFT] = 1'b1;
    else if (x > r) code[lc2d_pkg::OC_RIGHT] = 1'b1;
    if (y < t) code[lc2d_pkg::OC_TOP] = 1'b1;
    else if (y > b) code[lc2d_pkg::OC_BOTTOM] = 1'b1;
    return code;
  endfunction

  function automatic clip_t clip_segment(input coord_t sx, input coord_t sy,
                                         input coord_t ex, input coord_t ey);
    longint     px[2], py[2];
    longint     dx, dy, l, t, r, b;
    logic [3:0] code[2];
    int         moves, k;
    bit         accepted, done;
    clip_t      res;
    l = win_left; t = win_top; r = win_right; b = win_bottom;
    px[0] = sx; py[0] = sy; px[1] = ex; py[1] = ey;
    dx = px[1] - px[0];
    dy = py[1] - py[0];
    code[0] = region_code(px[0], py[0], l, t, r, b);
    code[1] = region_code(px[1], py[1], l, t, r, b);
    accepted = 1'b0;
    done = 1'b0;
    moves = 0;
    while (!done) begin
      if ((code[0] | code[1]) == 4'd0) begin
        accepted = 1'b1;
        done = 1'b1;
      end else if ((code[0] & code[1]) != 4'd0 ||
                   moves == int'(lc2d_pkg::MAX_MOVES)) begin
        done = 1'b1;
      end else begin
        // The slope always comes from the original endpoints, not the moved ones.
        k = (code[0] != 4'd0) ? 0 : 1;
        if (code[k][lc2d_pkg::OC_LEFT]) begin
          py[k] = clamp_coord(py[k] + edge_offset(dy, l - px[k], dx));
          px[k] = l;
        end else if (code[k][lc2d_pkg::OC_RIGHT]) begin
          py[k] = clamp_coord(py[k] + edge_offset(dy, r - px[k], dx));
          px[k] = r;
        end else if (code[k][lc2d_pkg::OC_TOP]) begin
          px[k] = clamp_coord(px[k] + edge_offset(dx, t - py[k], dy));
          py[k] = t;
        end else begin
          px[k] = clamp_coord(px[k] + edge_offset(dx, b - py[k], dy));
          py[k] = b;
        end
        code[k] = region_code(px[k], py[k], l, t, r, b);
        moves++;
      end
    end
    res = '0;
    res.visible = accepted;
    if (accepted) begin
      res.csx = coord_t'(px[0]);
      res.csy = coord_t'(py[0]);
      res.cex = coord_t'(px[1]);
      res.cey = coord_t'(py[1]);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready) begin
      if (expected_clips.size() == 0) begin
        $error("clip result transaction with no segment outstanding");
        errors++;
      end else begin
        want_clip = expected_clips.pop_front();
        check_field("visible", {63'd0, want_clip.visible}, {63'd0, res_if.visible});
        check_field("clipped_start_x", want_clip.csx, res_if.clipped_start_x);
        check_field("clipped_start_y", want_clip.csy, res_if.clipped_start_y);
        check_field("clipped_end_x", want_clip.cex, res_if.clipped_end_x);
        check_field("clipped_end_y", want_clip.cey, res_if.clipped_end_y);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Entered and left at a falling edge. Valid is only lowered for a gap, so a
  // back-to-back segment keeps it high without a second assignment in the step.
  task automatic drive_segment(input coord_t sx, input coord_t sy,
                               input coord_t ex, input coord_t ey);
    while ($urandom_range(99) < send_gap_pct) begin
      seg_if.valid <= 1'b0;
      @(negedge clk);
    end
    seg_if.valid   <= 1'b1;
    seg_if.start_x <= sx;
    seg_if.start_y <= sy;
    seg_if.end_x   <= ex;
    seg_if.end_y   <= ey;
    @(posedge clk);
    while (!seg_if.ready) @(posedge clk);
    expected_clips.push_back(clip_segment(sx, sy, ex, ey));
    @(negedge clk);
  endtask

  // Stops traffic and waits until every outstanding segment has produced its result.
  task automatic drain_segments();
    seg_if.valid <= 1'b0;
    while (expected_clips.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_window(input coord_t l, input coord_t t, input coord_t r,
                            input coord_t b);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= lc2d_pkg::CFG_WINDOW_LEFT;
    cfg_wdata <= l;
    @(negedge clk);
    cfg_index <= lc2d_pkg::CFG_WINDOW_TOP;
    cfg_wdata <= t;
    @(negedge clk);
    cfg_index <= lc2d_pkg::CFG_WINDOW_RIGHT;
    cfg_wdata <= r;
    @(negedge clk);
    cfg_index <= lc2d_pkg::CFG_WINDOW_BOTTOM;
    cfg_wdata <= b;
    @(negedge clk);
    cfg_we <= 1'b0;
    win_left   = l;
    win_top    = t;
    win_right  = r;
    win_bottom = b;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Somewhere within the span of the window edges or as far again plus 8 below it and plus 16 above it.
  function automatic coord_t coord_near(input longint lo, input longint hi);
    longint a, z, span;
    a = (lo < hi) ? lo : hi;
    z = (lo < hi) ? hi : lo;
    span = z - a + 8;
    return coord_t'(clamp_coord(a - span + longint'($urandom_range(32'(3 * span)))));
  endfunction

  function automatic coord_t coord_at_edge(input longint lo, input longint hi);
    int pick;
    pick = $urandom_range(5);
    return coord_t'(clamp_coord(((pick < 3) ? lo : hi) + (pick % 3) - 1));
  endfunction

  function automatic coord_t coord_extreme();
    case ($urandom_range(3))
      0: return coord_t'(COORD_MIN);
      1: return coord_t'(COORD_MAX);
      2: return coord_t'(0);
      default: return coord_t'(-1);
    endcase
  endfunction

  task automatic choose_window(input window_kind_t kind);
    coord_t l, t, r, b;
    case (kind)
      WIN_DEFAULT: begin
        l = '0; t = '0;
        r = coord_t'(lc2d_pkg::WIN_RIGHT_RESET);
        b = coord_t'(lc2d_pkg::WIN_BOTTOM_RESET);
      end
      WIN_NORMAL: begin
        l = coord_t'(longint'($urandom_range(600)) - 300);
        t = coord_t'(longint'($urandom_range(600)) - 300);
        r = coord_t'(longint'(l) + longint'($urandom_range(700, 1)));
        b = coord_t'(longint'(t) + longint'($urandom_range(700, 1)));
      end
      WIN_TINY: begin
        l = coord_t'(longint'($urandom_range(100)) - 50);
        t = coord_t'(longint'($urandom_range(100)) - 50);
        r = coord_t'(longint'(l) + longint'($urandom_range(3)));
        b = coord_t'(longint'(t) + longint'($urandom_range(3)));
      end
      WIN_FULL: begin
        l = coord_t'(COORD_MIN); t = coord_t'(COORD_MIN);
        r = coord_t'(COORD_MAX); b = coord_t'(COORD_MAX);
      end
      WIN_INVERTED: begin
        l = coord_t'(longint'($urandom_range(600)) - 300);
        t = coord_t'(longint'($urandom_range(600)) - 300);
        r = coord_t'(longint'(l) - longint'($urandom_range(200, 1)));
        b = ($urandom_range(1) != 0) ? coord_t'(longint'(t) - longint'($urandom_range(200, 1)))
                                     : coord_t'(longint'(t) + longint'($urandom_range(400)));
      end
      default: begin
        l = coord_t'($urandom); t = coord_t'($urandom);
        r = coord_t'($urandom); b = coord_t'($urandom);
      end
    endcase
    set_window(l, t, r, b);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Window straight out of reset, without any register write.
  task automatic test_default_window();
    drive_segment(10, 10, 600, 400);
    drive_segment(-50, 10, -5, 400);
    drive_segment(-100, 100, 100, 200);
    drive_segment(600, 100, 1000, 300);
    drive_segment(320, -100, 320, 600);
    drive_segment(-10, 240, 700, 240);
    drive_segment(-100, -100, 800, 600);
    drive_segment(-100, 300, 300, -500);
    drive_segment(coord_t'(COORD_MIN), coord_t'(COORD_MIN),
                  coord_t'(COORD_MAX), coord_t'(COORD_MAX));
    drive_segment(coord_t'(COORD_MAX), coord_t'(COORD_MIN),
                  coord_t'(COORD_MIN), coord_t'(COORD_MAX));
    drive_segment(0, 0, 0, 0);
    // Exact halves: one rounds up, the other rounds down away from zero.
    drive_segment(-1, 0, 1, 1);
    drive_segment(-1, 1, 1, 0);
    drain_segments();
  endtask

  task automatic test_odd_windows();
    // Inverted x range: the first move lands far outside and saturates.
    set_window(100, 0, -100, 479);
    drive_segment(101, 0, 99, 30000);
    drive_segment(0, 240, 200, 240);
    drain_segments();
    set_window(coord_t'(COORD_MIN), coord_t'(COORD_MIN),
               coord_t'(COORD_MAX), coord_t'(COORD_MAX));
    drive_segment(coord_t'(COORD_MIN), coord_t'(COORD_MAX),
                  coord_t'(COORD_MAX), coord_t'(COORD_MIN));
    drive_segment(0, 0, -1, -1);
    drain_segments();
    // A single-pixel window, where rounding can keep a point bouncing between edges.
    set_window(5, 5, 5, 5);
    drive_segment(0, 0, 10, 10);
    drive_segment(0, 10, 10, 0);
    drive_segment(0, 3, 10, 8);
    drive_segment(5, -100, 5, 100);
    drain_segments();
  endtask

  task automatic test_random_segments(input int gap_pct, input int stall_pct);
    coord_t sx, sy, ex, ey;
    int     mode;
    send_gap_pct = gap_pct;
    accept_stall_pct = stall_pct;
    for (int blk = 0; blk <= int'(WIN_WILD); blk++) begin
      choose_window(window_kind_t'(blk));
      for (int n = 0; n < ITEMS_PER_WINDOW; n++) begin
        mode = $urandom_range(99);
        if (mode < 55) begin
          sx = coord_near(win_left, win_right);
          sy = coord_near(win_top, win_bottom);
          ex = coord_near(win_left, win_right);
          ey = coord_near(win_top, win_bottom);
        end else if (mode < 70) begin
          sx = coord_t'($urandom); sy = coord_t'($urandom);
          ex = coord_t'($urandom); ey = coord_t'($urandom);
        end else if (mode < 85) begin
          sx = ($urandom_range(1) != 0) ? coord_at_edge(win_left, win_right)
                                        : coord_near(win_left, win_right);
          sy = ($urandom_range(1) != 0) ? coord_at_edge(win_top, win_bottom)
                                        : coord_near(win_top, win_bottom);
          ex = ($urandom_range(1) != 0) ? coord_at_edge(win_left, win_right)
                                        : coord_near(win_left, win_right);
          ey = ($urandom_range(1) != 0) ? coord_at_edge(win_top, win_bottom)
                                        : coord_near(win_top, win_bottom);
        end else if (mode < 93) begin
          sx = coord_near(win_left, win_right);
          sy = coord_near(win_top, win_bottom);
          ex = coord_near(win_left, win_right);
          ey = coord_near(win_top, win_bottom);
          if ($urandom_range(1) != 0) ex = sx;
          else ey = sy;
        end else begin
          sx = coord_extreme(); sy = coord_extreme();
          ex = ($urandom_range(1) != 0) ? coord_extreme() : coord_near(win_left, win_right);
          ey = ($urandom_range(1) != 0) ? coord_extreme() : coord_near(win_top, win_bottom);
        end
        drive_segment(sx, sy, ex, ey);
      end
      drain_segments();
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = lc2d_pkg::CFG_WINDOW_LEFT;
    cfg_wdata      = '0;
    seg_if.valid   = 1'b0;
    seg_if.start_x = '0;
    seg_if.start_y = '0;
    seg_if.end_x   = '0;
    seg_if.end_y   = '0;
    res_if.ready   = 1'b0;
    win_left       = '0;
    win_top        = '0;
    win_right      = coord_t'(lc2d_pkg::WIN_RIGHT_RESET);
    win_bottom     = coord_t'(lc2d_pkg::WIN_BOTTOM_RESET);
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_default_window();
    test_odd_windows();
    test_random_segments(38, 63);
    test_random_segments(63, 38);
    test_random_segments(0, 0);

    drain_segments();
    // Any clip result arriving after the drain is spurious.
    repeat (100) @(posedge clk);
    if (expected_clips.size() != 0) begin
      $error("%0d clip results never arrived", expected_clips.size());
      errors++;
    end
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
